### hw/rtl/lpg_pkg.sv
// shared constants and types for the line pixel generator
package lpg_pkg;

   // coordinate bits actually used, 2 to 6
   localparam int COORD_BITS    = 6;
   // fixed width of each coordinate field on the ports
   localparam int FIELD_BITS    = 6;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 16;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - 2 * FIELD_BITS;
   // decision term and increments, two's complement
   localparam int DT_BITS       = COORD_BITS + 3;
   localparam int QUEUE_DEPTH   = 2;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [DT_BITS-1:0]    term_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      term_type  decision;
      term_type  diag_inc;
      term_type  straight_inc;
      coord_type steps_left;
      logic      step_x_negative;
      logic      step_y_negative;
      logic      x_is_major;
   } setup_type;

endpackage

### hw/rtl/lpg_front.sv
// front end: takes a line request apart and works out the stepping setup
module lpg_front (
   input  logic [lpg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output lpg_pkg::setup_type                setup
);
   import lpg_pkg::*;

   coord_type sx, sy, ex, ey;
   coord_type dx, dy, dmaj, dmin;
   logic      x_less, y_less, xmaj;
   term_type  dmaj_w, dmin2_w;

   always_comb begin
      sx = req_tdata[0 * FIELD_BITS +: COORD_BITS];
      sy = req_tdata[1 * FIELD_BITS +: COORD_BITS];
      ex = req_tdata[2 * FIELD_BITS +: COORD_BITS];
      ey = req_tdata[3 * FIELD_BITS +: COORD_BITS];

      x_less = sx < ex;
      y_less = sy < ey;
      dx = x_less ? (ex - sx) : (sx - ex);
      dy = y_less ? (ey - sy) : (sy - ey);

      // ties go to the y axis
      xmaj = dx > dy;
      dmaj = xmaj ? dx : dy;
      dmin = xmaj ? dy : dx;

      dmaj_w  = DT_BITS'(dmaj);
      dmin2_w = DT_BITS'(dmin) << 1;

      setup.x               = sx;
      setup.y               = sy;
      setup.decision        = dmin2_w - dmaj_w;
      setup.diag_inc        = dmin2_w - (dmaj_w << 1);
      setup.straight_inc    = dmin2_w;
      setup.steps_left      = dmaj;
      setup.step_x_negative = !x_less;
      setup.step_y_negative = !y_less;
      setup.x_is_major      = xmaj;
   end

endmodule

### hw/rtl/lpg_queue.sv
// short queue of line setups between the front end and the stepper
module lpg_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_valid,
   output logic               wr_ready,
   input  lpg_pkg::setup_type wr_data,
   output logic               rd_valid,
   input  logic               rd_ready,
   output lpg_pkg::setup_type rd_data
);
   import lpg_pkg::*;

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   setup_type               entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    push, pop;

   assign wr_ready = count_ff != COUNT_BITS'(QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

### hw/rtl/lpg_back.sv
// stepper: walks one line setup pixel by pixel into an output register
module lpg_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            setup_valid,
   output logic                            setup_ready,
   input  lpg_pkg::setup_type              setup,
   output logic                            pix_valid,
   input  logic                            pix_ready,
   output logic [lpg_pkg::FIELD_BITS-1:0]  pix_x,
   output logic [lpg_pkg::FIELD_BITS-1:0]  pix_y,
   output logic                            pix_last
);
   import lpg_pkg::*;

   logic      busy_ff, busy_in;
   setup_type line_ff, line_in;
   logic      out_valid_ff, out_valid_in;
   coord_type out_x_ff, out_x_in;
   coord_type out_y_ff, out_y_in;
   logic      out_last_ff, out_last_in;
   logic      emit, done, diag, move_x, move_y;

   assign setup_ready = !busy_ff;
   assign pix_valid   = out_valid_ff;
   assign pix_x       = FIELD_BITS'(out_x_ff);
   assign pix_y       = FIELD_BITS'(out_y_ff);
   assign pix_last    = out_last_ff;

   always_comb begin
      busy_in      = busy_ff;
      line_in      = line_ff;
      out_valid_in = out_valid_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_last_in  = out_last_ff;

      emit   = busy_ff && (!out_valid_ff || pix_ready);
      done   = line_ff.steps_left == '0;
      // minor axis moves when the decision term is not negative
      diag   = !line_ff.decision[DT_BITS-1];
      move_x = line_ff.x_is_major || diag;
      move_y = !line_ff.x_is_major || diag;

      if (out_valid_ff && pix_ready) begin
         out_valid_in = 1'b0;
      end

      if (!busy_ff) begin
         if (setup_valid) begin
            busy_in = 1'b1;
            line_in = setup;
         end
      end else if (emit) begin
         out_valid_in = 1'b1;
         out_x_in     = line_ff.x;
         out_y_in     = line_ff.y;
         out_last_in  = done;
         if (done) begin
            busy_in = 1'b0;
         end else begin
            if (move_x) begin
               line_in.x = line_ff.step_x_negative ? line_ff.x - 1'b1 : line_ff.x + 1'b1;
            end
            if (move_y) begin
               line_in.y = line_ff.step_y_negative ? line_ff.y - 1'b1 : line_ff.y + 1'b1;
            end
            line_in.decision   = line_ff.decision +
                                 (diag ? line_ff.diag_inc : line_ff.straight_inc);
            line_in.steps_left = line_ff.steps_left - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff     <= line_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

endmodule

### hw/rtl/line_pixel_generator.sv
// top level of the line pixel generator: front end, setup queue and stepper
// each request is written into the setup queue, then loaded into the stepper, which
// registers its pixels in the output register: a line of n pixels, up to 64, comes
// out at one pixel per cycle while rsp_tready holds, and the next line is loaded only
// after its last pixel; reset clears the queue, the stepper and the output register
module line_pixel_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
   input  logic [lpg_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // pixel_x [5:0], pixel_y [11:6], zeros above
   output logic [lpg_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                              rsp_tlast
);
   import lpg_pkg::*;

   setup_type               front_setup;
   setup_type               queue_setup;
   logic                    queue_valid;
   logic                    back_ready;
   logic [FIELD_BITS-1:0]   pix_x, pix_y;

   lpg_front u_front (
      .req_tdata (req_tdata),
      .setup     (front_setup)
   );

   lpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (req_tvalid),
      .wr_ready (req_tready),
      .wr_data  (front_setup),
      .rd_valid (queue_valid),
      .rd_ready (back_ready),
      .rd_data  (queue_setup)
   );

   lpg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .setup_valid (queue_valid),
      .setup_ready (back_ready),
      .setup       (queue_setup),
      .pix_valid   (rsp_tvalid),
      .pix_ready   (rsp_tready),
      .pix_x       (pix_x),
      .pix_y       (pix_y),
      .pix_last    (rsp_tlast)
   );

   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, pix_y, pix_x};

endmodule

### verif/tb_line_pixel_generator.sv
// testbench for the line pixel generator: directed and random line requests checked per pixel
`timescale 1ns / 1ps

module tb_line_pixel_generator;
   import lpg_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_LINES = 48;
   localparam int COORD_MAX    = (1 << FIELD_BITS) - 1;

   typedef logic [FIELD_BITS-1:0] field_type;

   typedef struct {
      field_type x;
      field_type y;
      logic      last;
   } pixel_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;

   // pixels still owed by the block, oldest first
   pixel_type pixel_queue[$];

   // predictor state: pen position, decision term and major steps to go
   int pen_x;
   int pen_y;
   int pen_term;
   int pen_steps;

   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_request  = 0;
   int hold_left     = 0;
   int error_count   = 0;
   int cycle_count   = 0;

   line_pixel_generator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_pixels
      pixel_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_queue.size() == 0) begin
            $error("pixel transaction with nothing expected: x %0d y %0d last %0b",
                   rsp_tdata[FIELD_BITS-1:0], rsp_tdata[2*FIELD_BITS-1:FIELD_BITS], rsp_tlast);
            error_count++;
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_tdata[FIELD_BITS-1:0] !== want.x) begin
               $error("pixel_x: expected %0d, got %0d", want.x, rsp_tdata[FIELD_BITS-1:0]);
               error_count++;
            end
            if (rsp_tdata[2*FIELD_BITS-1:FIELD_BITS] !== want.y) begin
               $error("pixel_y: expected %0d, got %0d", want.y,
                      rsp_tdata[2*FIELD_BITS-1:FIELD_BITS]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("is_last: expected %0b, got %0b", want.last, rsp_tlast);
               error_count++;
            end
            if (rsp_tdata[RSP_DATA_BITS-1:2*FIELD_BITS] !== '0) begin
               $error("tdata padding: expected 0, got %0h",
                      rsp_tdata[RSP_DATA_BITS-1:2*FIELD_BITS]);
               error_count++;
            end
         end
      end
   end

   // walks the line with the integer decision term and queues every pixel
   task automatic trace_line(input field_type sx_in, input field_type sy_in,
                             input field_type ex_in, input field_type ey_in);
      int        mask_c = (1 << COORD_BITS) - 1;
      int        sx, sy, ex, ey, dx, dy, step_x, step_y, major, minor;
      int        diag_inc, straight_inc;
      bit        x_major;
      pixel_type pix;
      sx = int'(sx_in) & mask_c;
      sy = int'(sy_in) & mask_c;
      ex = int'(ex_in) & mask_c;
      ey = int'(ey_in) & mask_c;
      dx = (ex > sx) ? ex - sx : sx - ex;
      dy = (ey > sy) ? ey - sy : sy - ey;
      step_x = (sx < ex) ? 1 : -1;
      step_y = (sy < ey) ? 1 : -1;
      // ties go along y
      x_major = dx > dy;
      major = x_major ? dx : dy;
      minor = x_major ? dy : dx;
      diag_inc = 2 * (minor - major);
      straight_inc = 2 * minor;
      pen_x = sx;
      pen_y = sy;
      pen_term = 2 * minor - major;
      pen_steps = major;
      forever begin
         pix.x = field_type'(pen_x);
         pix.y = field_type'(pen_y);
         pix.last = (pen_steps == 0);
         pixel_queue.push_back(pix);
         if (pen_steps == 0) break;
         if (pen_term >= 0) begin
            if (x_major) pen_y += step_y;
            else pen_x += step_x;
            pen_term += diag_inc;
         end else begin
            pen_term += straight_inc;
         end
         if (x_major) pen_x += step_x;
         else pen_y += step_y;
         pen_steps--;
      end
   endtask

   // offers one line request, with random idle cycles first, and predicts it once taken
   task automatic send_line(input field_type sx, input field_type sy,
                            input field_type ex, input field_type ey);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ey, ex, sy, sx};
      do @(posedge clock); while (!req_tready);
      trace_line(sx, sy, ex, ey);
   endtask

   task automatic wait_for_pixels();
      req_tvalid <= 1'b0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int ready_stall_pct);
      send_idle_pct = send_pct;
      stall_pct     = ready_stall_pct;
   endtask

   function automatic field_type random_coord();
      return field_type'($urandom_range(COORD_MAX));
   endfunction

   // a coordinate a few steps from c, kept on the grid
   function automatic field_type near_coord(input field_type c);
      int tmp;
      tmp = int'(c) + int'($urandom_range(8)) - 4;
      if (tmp < 0) tmp = 0;
      else if (tmp > COORD_MAX) tmp = COORD_MAX;
      return field_type'(tmp);
   endfunction

   task automatic test_single_pixel();
      send_line(0, 0, 0, 0);
      send_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
   endtask

   // zero minor extent, both directions, full length
   task automatic test_axis_lines();
      send_line(0, 5, COORD_MAX, 5);
      send_line(COORD_MAX, 58, 0, 58);
      send_line(7, 0, 7, COORD_MAX);
      send_line(56, COORD_MAX, 56, 0);
   endtask

   // equal extents, where the step goes along y
   task automatic test_diagonals();
      send_line(0, 0, COORD_MAX, COORD_MAX);
      send_line(COORD_MAX, 0, 0, COORD_MAX);
      send_line(COORD_MAX, COORD_MAX, 0, 0);
      send_line(0, COORD_MAX, COORD_MAX, 0);
   endtask

   task automatic test_octants();
      send_line(32, 32, 40, 35);
      send_line(32, 32, 35, 40);
      send_line(32, 32, 24, 35);
      send_line(32, 32, 29, 40);
      send_line(32, 32, 24, 29);
      send_line(32, 32, 29, 24);
      send_line(32, 32, 40, 29);
      send_line(32, 32, 35, 24);
      send_line(0, 0, COORD_MAX, 1);
      send_line(1, COORD_MAX, 0, 0);
   endtask

   // receiver holds off while requests keep coming, so the input has to stall
   task automatic test_input_stall();
      field_type sx, sy;
      hold_request = 300;
      repeat (8) begin
         sx = random_coord();
         sy = random_coord();
         send_line(sx, sy, near_coord(sx), near_coord(sy));
      end
      wait_for_pixels();
   endtask

   task automatic test_random_lines(input int count);
      field_type sx, sy, ex, ey, swap;
      int        d;
      repeat (count) begin
         sx = random_coord();
         sy = random_coord();
         ex = random_coord();
         ey = random_coord();
         case ($urandom_range(3))
            0: begin
               ex = near_coord(sx);
               ey = near_coord(sy);
            end
            1: begin
               case ($urandom_range(2))
                  0: ey = sy;
                  1: ex = sx;
                  default: begin
                     d  = $urandom_range(COORD_MAX);
                     sx = field_type'($urandom_range(COORD_MAX - d));
                     sy = field_type'($urandom_range(COORD_MAX - d));
                     ex = field_type'(int'(sx) + d);
                     ey = field_type'(int'(sy) + d);
                     if ($urandom_range(1)) begin
                        swap = sx; sx = ex; ex = swap;
                     end
                     if ($urandom_range(1)) begin
                        swap = sy; sy = ey; ey = swap;
                     end
                  end
               endcase
            end
            default: ;
         endcase
         send_line(sx, sy, ex, ey);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idling(0, 0);
      test_single_pixel();
      test_axis_lines();
      set_idling(46, 46);
      test_diagonals();
      test_octants();
      wait_for_pixels();
      set_idling(0, 0);
      test_input_stall();
      set_idling(0, 0);
      test_random_lines(RANDOM_LINES);
      set_idling(46, 0);
      test_random_lines(RANDOM_LINES);
      wait_for_pixels();
      set_idling(0, 46);
      test_random_lines(RANDOM_LINES);
      set_idling(38, 38);
      test_random_lines(RANDOM_LINES);
      wait_for_pixels();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pixel_queue.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
